FILE: rtl/tfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_pkg
// shared constants, frame descriptor type and checksum helper for the
// telemetry frame stuffer
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] PRELUDE_ID  = 8'h98;
    localparam logic [7:0] HEADER_BYTE = 8'h10;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_MASK = 8'h20;
    localparam logic [7:0] CHECK_BASE  = 8'hFF;

    localparam int BODY_BYTES    = 8;
    localparam int SUMMED_BYTES  = 7;
    localparam int QUEUE_DEPTH   = 2;
    localparam int POS_W         = 4;
    localparam int BODY_IDX_W    = $clog2(BODY_BYTES);

    localparam logic [POS_W-1:0] POS_START      = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST_BODY = 4'd2;
    localparam logic [POS_W-1:0] POS_LAST       = 4'd9;

    typedef struct packed {
        logic                           prelude;
        logic [BODY_BYTES-1:0][7:0]     body;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // byte sum with end-around carry
    function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        begin
            t = {1'b0, s} + {1'b0, b};
            return t[7:0] + {7'b0, t[8]};
        end
    endfunction

endpackage

FILE: rtl/tfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_front
// takes a telemetry sample, lays out the frame body and its checksum
// ----------------------------------------------------------------------------
module tfs_front
    import tfs_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sensor_id,
    input  logic [31:0] sample_value,
    input  logic        with_prelude,
    input  q_status_t   q_status,
    output logic        push,
    output frame_t      frame
);

    logic [10:0] total;
    logic [8:0]  fold;
    logic [7:0]  sum;

    always_comb
    begin
        frame.prelude = with_prelude;
        frame.body[0] = HEADER_BYTE;
        frame.body[1] = sensor_id[7:0];
        frame.body[2] = sensor_id[15:8];
        frame.body[3] = sample_value[7:0];
        frame.body[4] = sample_value[15:8];
        frame.body[5] = sample_value[23:16];
        frame.body[6] = sample_value[31:24];
        // plain sum of the first seven body bytes, carries folded back in afterwards
        total = 11'd0;
        for (int i = 0; i < SUMMED_BYTES; i++)
        begin
            total = total + {3'b000, frame.body[i]};
        end
        fold = {1'b0, total[7:0]} + {6'b000000, total[10:8]};
        sum  = sum_add(fold[7:0], {7'b0000000, fold[8]});
        frame.body[7] = CHECK_BASE - sum;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid & ~q_status.full;

endmodule

FILE: rtl/tfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_queue
// short frame descriptor queue between front and back
// ----------------------------------------------------------------------------
module tfs_queue
    import tfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  frame_t    push_frame,
    input  logic      pop,
    output frame_t    head,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    frame_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    assign head           = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_DEPTH);
    assign q_status.empty = (count_reg == '0);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_DEPTH)
        else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/tfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_back
// walks the head frame, one output byte per cycle while out_stall is low and
// the queue holds a frame, escapes body bytes, drives the output register
// ----------------------------------------------------------------------------
module tfs_back
    import tfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  frame_t    head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output logic [7:0] out_byte,
    output logic      frame_end
);

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             frame_end_reg, frame_end_next;
    logic             first_reg, first_next;
    logic             esc_pending_reg, esc_pending_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             load;
    logic             step;
    logic [POS_W-1:0] pos;
    logic [7:0]       cur;
    logic             in_body;
    logic [7:0]       beat_byte;
    logic             advance;
    logic             is_last;
    logic [POS_W-1:0] body_off;

    always_comb
    begin
        load     = !out_valid_reg || !out_stall;
        step     = load && !q_status.empty;
        pos      = first_reg ? (head.prelude ? POS_START : POS_FIRST_BODY) : pos_reg;
        in_body  = (pos >= POS_FIRST_BODY);
        body_off = pos - POS_FIRST_BODY;
        if (in_body)
        begin
            cur = head.body[body_off[BODY_IDX_W-1:0]];
        end
        else
        begin
            cur = pos[0] ? PRELUDE_ID : START_BYTE;
        end

        if (esc_pending_reg)
        begin
            beat_byte = cur & ~ESCAPE_MASK;
            advance   = 1'b1;
        end
        else if (in_body && (cur inside {START_BYTE, ESCAPE_BYTE}))
        begin
            beat_byte = ESCAPE_BYTE;
            advance   = 1'b0;
        end
        else
        begin
            beat_byte = cur;
            advance   = 1'b1;
        end
        is_last = advance && (pos == POS_LAST);
        pop     = step && is_last;

        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        frame_end_next   = frame_end_reg;
        first_next       = first_reg;
        esc_pending_next = esc_pending_reg;
        pos_next         = pos_reg;
        if (step)
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = beat_byte;
            frame_end_next   = is_last;
            esc_pending_next = !advance;
            first_next       = is_last;
            if (is_last)
            begin
                pos_next = POS_START;
            end
            else
            begin
                pos_next = advance ? pos + 1'b1 : pos;
            end
        end
        else if (load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            first_reg       <= 1'b1;
            esc_pending_reg <= 1'b0;
            pos_reg         <= POS_START;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            first_reg       <= first_next;
            esc_pending_reg <= esc_pending_next;
            pos_reg         <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

`ifndef SYNTH
    a_esc_follows_marker: assert property (@(posedge clk) disable iff (!rst_n)
        esc_pending_reg |-> (out_valid_reg && out_byte_reg == ESCAPE_BYTE))
        else $error("escape pending without escape byte in output register");
    a_end_not_mid_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> !esc_pending_reg)
        else $error("frame end with escape still pending");
    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |-> !q_status.empty)
        else $error("frame in progress lost its descriptor");
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte position beyond frame");
`endif

endmodule

FILE: rtl/telemetry_frame_stuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_stuffer
// builds a checksummed, byte stuffed telemetry frame per sample
// ----------------------------------------------------------------------------
// path: a sample beat is written into the queue, then its first byte is loaded into the output register
// throughput: one output byte per cycle while out_stall is low, set by
// the single byte output register draining the head frame of the queue
// samples keep being taken while the queue has room
// reset: asynchronous, clears the queue and the byte sequencer, output idle
module telemetry_frame_stuffer
    import tfs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sensor_id,
    input  logic [31:0] sample_value,
    input  logic        with_prelude,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end
);

    q_status_t q_status;
    frame_t    push_frame;
    frame_t    head;
    logic      push;
    logic      pop;

    tfs_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sensor_id    (sensor_id),
        .sample_value (sample_value),
        .with_prelude (with_prelude),
        .q_status     (q_status),
        .push         (push),
        .frame        (push_frame)
    );

    tfs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    tfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule
